// ===== sv/fctag_pkg.sv =====
package fctag_pkg;

    localparam int TEX_W_LOG2_DEF = 6;
    localparam int TEX_H_LOG2_DEF = 6;
    localparam int FRAC_BITS_DEF  = 16;

    // dir and plane are Q2.14
    localparam int DIR_FRAC = 14;
    // magnitude of a difference or double of two Q2.14 values
    localparam int MAG_W    = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DIR_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POS_X   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_POS_Y   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT  = 3'd7;

    localparam logic [15:0] DIR_X_RST   = 16'd16384;
    localparam logic [15:0] DIR_Y_RST   = 16'd0;
    localparam logic [15:0] PLANE_X_RST = 16'd0;
    localparam logic [15:0] PLANE_Y_RST = 16'd10813;
    localparam logic [31:0] POS_X_RST   = 32'd0;
    localparam logic [31:0] POS_Y_RST   = 32'd0;
    localparam logic [11:0] WIDTH_RST   = 12'd640;
    localparam logic [11:0] HEIGHT_RST  = 12'd480;

    typedef logic [2:0] phase_t;

    // row setup steps of the shared multiply/divide unit, in order
    localparam phase_t PH_DIST = 3'd0;
    localparam phase_t PH_WX   = 3'd1;
    localparam phase_t PH_WY   = 3'd2;
    localparam phase_t PH_SX   = 3'd3;
    localparam phase_t PH_DSX  = 3'd4;
    localparam phase_t PH_SY   = 3'd5;
    localparam phase_t PH_DSY  = 3'd6;

    typedef struct packed {
        logic   load_pix;
        logic   start;
        phase_t phase;
        logic   load_out;
        logic   out_from_reg;
    } fctag_cmd_t;

    typedef struct packed {
        logic need_setup;
        logic out_busy;
        logic unit_done;
    } fctag_sts_t;

endpackage

// ===== sv/fctag_ifs.sv =====
interface fctag_pix_if;
    logic        valid;
    logic        ready;
    logic [10:0] row;
    logic [10:0] column;

    modport source (output valid, output row, output column, input ready);
    modport sink   (input valid, input row, input column, output ready);
endinterface

interface fctag_tex_if;
    logic        valid;
    logic        ready;
    logic [9:0]  tex_u;
    logic [9:0]  tex_v;
    logic [19:0] texel_index;
    logic [10:0] out_column;
    logic [10:0] floor_row;
    logic [10:0] ceiling_row;
    logic        bad_pixel;

    modport source (output valid, output tex_u, output tex_v, output texel_index,
                    output out_column, output floor_row, output ceiling_row,
                    output bad_pixel, input ready);
    modport sink   (input valid, input tex_u, input tex_v, input texel_index,
                    input out_column, input floor_row, input ceiling_row,
                    input bad_pixel, output ready);
endinterface

// ===== sv/fctag_ctrl.sv =====
module fctag_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  fctag_pkg::fctag_sts_t  sts,
    output fctag_pkg::fctag_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]        state_reg, state_next;
    fctag_pkg::phase_t phase_reg, phase_next;
    fctag_pkg::phase_t phase_succ;
    logic              out_free;

    assign out_free = !sts.out_busy;

    always_comb
    begin
        case (phase_reg)
            fctag_pkg::PH_DIST: phase_succ = fctag_pkg::PH_WX;
            fctag_pkg::PH_WX:   phase_succ = fctag_pkg::PH_WY;
            fctag_pkg::PH_WY:   phase_succ = fctag_pkg::PH_SX;
            fctag_pkg::PH_SX:   phase_succ = fctag_pkg::PH_DSX;
            fctag_pkg::PH_DSX:  phase_succ = fctag_pkg::PH_SY;
            fctag_pkg::PH_SY:   phase_succ = fctag_pkg::PH_DSY;
            default:            phase_succ = fctag_pkg::PH_DIST;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        in_ready   = 1'b0;
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = out_free;
                if (in_valid && out_free)
                begin
                    if (sts.need_setup)
                    begin
                        cmd.load_pix = 1'b1;
                        cmd.start    = 1'b1;
                        cmd.phase    = fctag_pkg::PH_DIST;
                        phase_next   = fctag_pkg::PH_DIST;
                        state_next   = ST_RUN;
                    end
                    else
                    begin
                        cmd.load_out = 1'b1;
                    end
                end
            end
            ST_RUN:
            begin
                if (sts.unit_done)
                begin
                    if (phase_reg == fctag_pkg::PH_DSY)
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        cmd.phase  = phase_succ;
                        phase_next = phase_succ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    cmd.load_out     = 1'b1;
                    cmd.out_from_reg = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= fctag_pkg::PH_DIST;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

// ===== sv/fctag_datapath.sv =====
module fctag_datapath #(
    parameter int TEX_W_LOG2 = fctag_pkg::TEX_W_LOG2_DEF,
    parameter int TEX_H_LOG2 = fctag_pkg::TEX_H_LOG2_DEF,
    parameter int FRAC_BITS  = fctag_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [fctag_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fctag_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [10:0]                         row,
    input  logic [10:0]                         column,
    input  logic                                out_ready,
    output logic                                out_valid,
    output logic [9:0]                          tex_u,
    output logic [9:0]                          tex_v,
    output logic [19:0]                         texel_index,
    output logic [10:0]                         out_column,
    output logic [10:0]                         floor_row,
    output logic [10:0]                         ceiling_row,
    output logic                                bad_pixel,
    input  fctag_pkg::fctag_cmd_t               cmd,
    output fctag_pkg::fctag_sts_t               sts
);

    localparam int DW    = 11 + FRAC_BITS;
    localparam int MW    = fctag_pkg::MAG_W;
    localparam int PW    = DW + MW;
    localparam int NW    = PW - fctag_pkg::DIR_FRAC;
    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NW - 1);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MW - 1);

    // configuration
    logic [15:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [31:0] pos_x_reg, pos_y_reg;
    logic [11:0] fw_reg, fh_reg;

    // walk state
    logic [31:0] world_x_reg, world_y_reg, step_x_reg, step_y_reg;

    // shared multiply/divide unit
    fctag_pkg::phase_t phase_reg;
    logic              run_reg, done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NW-1:0]     num_reg;
    logic [11:0]       rem_reg, den_reg;
    logic [PW-1:0]     prod_reg, mcand_reg;
    logic [MW-1:0]     mplier_reg;
    logic              sign_reg;
    logic [DW-1:0]     dist_reg;
    logic [10:0]       row_reg, col_reg;

    // output word
    logic        out_valid_reg;
    logic [9:0]  tu_reg, tv_reg;
    logic [19:0] idx_reg;
    logic [10:0] ocol_reg, frow_reg, crow_reg;
    logic        bad_reg;

    function automatic logic pix_bad(input logic [10:0] r, input logic [10:0] c,
                                     input logic [11:0] fw, input logic [11:0] fh);
        return (r < fh[11:1]) || ({1'b0, r} >= fh) || ({1'b0, c} >= fw);
    endfunction

    function automatic logic [MW-1:0] mag(input logic [MW-1:0] v);
        return v[MW-1] ? MW'(~v + 1'b1) : v;
    endfunction

    function automatic logic [9:0] tex_coord(input logic [31:0] w, input int tl);
        logic [31:0]          m;
        logic [FRAC_BITS+9:0] t;
        m = w[31] ? (32'd0 - w) : w;
        t = ({10'd0, m[FRAC_BITS-1:0]} << tl) >> FRAC_BITS;
        if (w[31])
        begin
            t = {(FRAC_BITS + 10){1'b0}} - t;
        end
        return t[9:0] & 10'((1 << tl) - 1);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_x_reg   <= fctag_pkg::DIR_X_RST;
            dir_y_reg   <= fctag_pkg::DIR_Y_RST;
            plane_x_reg <= fctag_pkg::PLANE_X_RST;
            plane_y_reg <= fctag_pkg::PLANE_Y_RST;
            pos_x_reg   <= fctag_pkg::POS_X_RST;
            pos_y_reg   <= fctag_pkg::POS_Y_RST;
            fw_reg      <= fctag_pkg::WIDTH_RST;
            fh_reg      <= fctag_pkg::HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fctag_pkg::REG_DIR_X:   dir_x_reg   <= cfg_data[15:0];
                fctag_pkg::REG_DIR_Y:   dir_y_reg   <= cfg_data[15:0];
                fctag_pkg::REG_PLANE_X: plane_x_reg <= cfg_data[15:0];
                fctag_pkg::REG_PLANE_Y: plane_y_reg <= cfg_data[15:0];
                fctag_pkg::REG_POS_X:   pos_x_reg   <= cfg_data;
                fctag_pkg::REG_POS_Y:   pos_y_reg   <= cfg_data;
                fctag_pkg::REG_WIDTH:   fw_reg      <= cfg_data[11:0];
                fctag_pkg::REG_HEIGHT:  fh_reg      <= cfg_data[11:0];
                default:                fw_reg      <= fw_reg;
            endcase
        end
    end

    // row offset below the horizon, horizon row counts as one
    logic [10:0]        p_raw, p_val;
    logic signed [16:0] dxp, dyp;
    logic [MW-1:0]      twice_px, twice_py;

    assign p_raw    = row - fh_reg[11:1];
    assign p_val    = (p_raw == 11'd0) ? 11'd1 : p_raw;
    assign dxp      = $signed({dir_x_reg[15], dir_x_reg}) - $signed({plane_x_reg[15], plane_x_reg});
    assign dyp      = $signed({dir_y_reg[15], dir_y_reg}) - $signed({plane_y_reg[15], plane_y_reg});
    assign twice_px = {plane_x_reg, 1'b0};
    assign twice_py = {plane_y_reg, 1'b0};

    // one restoring divide step and one shift-add multiply step
    logic          is_div, last;
    logic [12:0]   trial, diff;
    logic          ge;
    logic [11:0]   rem_step;
    logic [NW-1:0] num_step;
    logic [PW-1:0] prod_step;

    assign is_div    = (phase_reg == fctag_pkg::PH_DIST) || (phase_reg == fctag_pkg::PH_DSX)
                    || (phase_reg == fctag_pkg::PH_DSY);
    assign last      = is_div ? (cnt_reg == DIV_LAST) : (cnt_reg == MUL_LAST);
    assign trial     = {rem_reg, num_reg[NW-1]};
    assign diff      = trial - {1'b0, den_reg};
    assign ge        = trial >= {1'b0, den_reg};
    assign rem_step  = ge ? diff[11:0] : trial[11:0];
    assign num_step  = {num_reg[NW-2:0], ge};
    assign prod_step = prod_reg + (mplier_reg[0] ? mcand_reg : {PW{1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= fctag_pkg::PH_DIST;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start)
            begin
                phase_reg <= cmd.phase;
                run_reg   <= 1'b1;
                cnt_reg   <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_pix)
        begin
            row_reg <= row;
            col_reg <= column;
        end
        if (cmd.start)
        begin
            rem_reg  <= '0;
            prod_reg <= '0;
            case (cmd.phase)
                fctag_pkg::PH_DIST:
                begin
                    num_reg <= NW'({fh_reg, {(FRAC_BITS - 1){1'b0}}});
                    den_reg <= {1'b0, p_val};
                end
                fctag_pkg::PH_WX:
                begin
                    mcand_reg  <= PW'(dist_reg);
                    mplier_reg <= mag(dxp);
                    sign_reg   <= dxp[16];
                end
                fctag_pkg::PH_WY:
                begin
                    mcand_reg  <= PW'(dist_reg);
                    mplier_reg <= mag(dyp);
                    sign_reg   <= dyp[16];
                end
                fctag_pkg::PH_SX:
                begin
                    mcand_reg  <= PW'(dist_reg);
                    mplier_reg <= mag(twice_px);
                    sign_reg   <= plane_x_reg[15];
                end
                fctag_pkg::PH_SY:
                begin
                    mcand_reg  <= PW'(dist_reg);
                    mplier_reg <= mag(twice_py);
                    sign_reg   <= plane_y_reg[15];
                end
                default:
                begin
                    // divide the truncated product magnitude by the frame width
                    num_reg <= prod_reg[PW-1:fctag_pkg::DIR_FRAC];
                    den_reg <= fw_reg;
                end
            endcase
        end
        else if (run_reg)
        begin
            if (is_div)
            begin
                num_reg <= num_step;
                rem_reg <= rem_step;
                if (last && (phase_reg == fctag_pkg::PH_DIST))
                begin
                    dist_reg <= num_step[DW-1:0];
                end
            end
            else
            begin
                prod_reg   <= prod_step;
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
        end
    end

    // finish a setup step: signed product floored by 2^14, or signed quotient
    logic signed [PW:0] sprod, sprod_sh;
    logic signed [NW:0] squo;
    logic [31:0]        start_off, step_val, pos_sel;

    assign sprod     = sign_reg ? -$signed({1'b0, prod_reg}) : $signed({1'b0, prod_reg});
    assign sprod_sh  = sprod >>> fctag_pkg::DIR_FRAC;
    assign start_off = 32'(sprod_sh);
    assign squo      = sign_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
    assign step_val  = 32'(squo);
    assign pos_sel   = (phase_reg == fctag_pkg::PH_WX) ? pos_x_reg : pos_y_reg;

    // pixel being answered
    logic [10:0] src_row, src_col;
    logic        src_bad;
    logic [9:0]  tu_val, tv_val;
    logic [11:0] crow_full;

    assign src_row   = cmd.out_from_reg ? row_reg : row;
    assign src_col   = cmd.out_from_reg ? col_reg : column;
    assign src_bad   = pix_bad(src_row, src_col, fw_reg, fh_reg);
    assign tu_val    = tex_coord(world_x_reg, TEX_W_LOG2);
    assign tv_val    = tex_coord(world_y_reg, TEX_H_LOG2);
    assign crow_full = fh_reg - {1'b0, src_row} - 12'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            world_x_reg <= '0;
            world_y_reg <= '0;
            step_x_reg  <= '0;
            step_y_reg  <= '0;
        end
        else if (done_reg)
        begin
            case (phase_reg)
                fctag_pkg::PH_WX:  world_x_reg <= pos_sel + start_off;
                fctag_pkg::PH_WY:  world_y_reg <= pos_sel + start_off;
                fctag_pkg::PH_DSX: step_x_reg  <= step_val;
                fctag_pkg::PH_DSY: step_y_reg  <= step_val;
                default:           step_x_reg  <= step_x_reg;
            endcase
        end
        else if (cmd.load_out && !src_bad)
        begin
            // advance one pixel
            world_x_reg <= world_x_reg + step_x_reg;
            world_y_reg <= world_y_reg + step_y_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            ocol_reg <= src_col;
            frow_reg <= src_row;
            bad_reg  <= src_bad;
            if (src_bad)
            begin
                tu_reg   <= '0;
                tv_reg   <= '0;
                idx_reg  <= '0;
                crow_reg <= '0;
            end
            else
            begin
                tu_reg   <= tu_val;
                tv_reg   <= tv_val;
                idx_reg  <= ({10'd0, tv_val} << TEX_W_LOG2) + {10'd0, tu_val};
                crow_reg <= crow_full[10:0];
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign tex_u       = tu_reg;
    assign tex_v       = tv_reg;
    assign texel_index = idx_reg;
    assign out_column  = ocol_reg;
    assign floor_row   = frow_reg;
    assign ceiling_row = crow_reg;
    assign bad_pixel   = bad_reg;

    assign sts.need_setup = (column == 11'd0) && !pix_bad(row, column, fw_reg, fh_reg);
    assign sts.out_busy   = out_valid_reg && !out_ready;
    assign sts.unit_done  = done_reg;

endmodule

// ===== sv/floor_ceiling_texel_address_gen_core.sv =====
// Floor/ceiling texel address generator. Send lower-half pixels in raster
// order on pix_in; each one returns a word on tex_out with its texel
// coordinates, texel index, frame column and floor and mirrored ceiling rows.
// Pixels outside the lower half or the frame come back with bad_pixel set
// and leave the walk state alone. Any pixel in a column other than zero,
// and a bad pixel in column zero, is taken one per cycle while tex_out is not
// stalled. A valid pixel in column zero sets up its row on a shared
// shift-add multiplier and restoring divider, in three divisions and four
// multiplies, and its word appears and the next pixel is taken only once
// the setup is done. Positions are Q16.16 at the default FRAC_BITS. Write the
// configuration registers only while no pixel is in flight.
module floor_ceiling_texel_address_gen_core #(
    parameter int TEX_W_LOG2 = fctag_pkg::TEX_W_LOG2_DEF,
    parameter int TEX_H_LOG2 = fctag_pkg::TEX_H_LOG2_DEF,
    parameter int FRAC_BITS  = fctag_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [fctag_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [fctag_pkg::CFG_DATA_W-1:0] cfg_data,
    fctag_pix_if.sink                        pix_in,
    fctag_tex_if.source                      tex_out
);

    fctag_pkg::fctag_cmd_t cmd;
    fctag_pkg::fctag_sts_t sts;

    fctag_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pix_in.valid),
        .in_ready (pix_in.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fctag_datapath #(
        .TEX_W_LOG2 (TEX_W_LOG2),
        .TEX_H_LOG2 (TEX_H_LOG2),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .row         (pix_in.row),
        .column      (pix_in.column),
        .out_ready   (tex_out.ready),
        .out_valid   (tex_out.valid),
        .tex_u       (tex_out.tex_u),
        .tex_v       (tex_out.tex_v),
        .texel_index (tex_out.texel_index),
        .out_column  (tex_out.out_column),
        .floor_row   (tex_out.floor_row),
        .ceiling_row (tex_out.ceiling_row),
        .bad_pixel   (tex_out.bad_pixel),
        .cmd         (cmd),
        .sts         (sts)
    );

endmodule

// ===== sv/fctag_checker.sv =====
module fctag_checker #(
    parameter int TEX_W_LOG2 = fctag_pkg::TEX_W_LOG2_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        pix_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [9:0]  tex_u,
    input logic [9:0]  tex_v,
    input logic [19:0] texel_index,
    input logic [10:0] ceiling_row,
    input logic        bad_pixel
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(texel_index))
        else $error("result word dropped or changed while stalled");

    a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        pix_ready |-> !(out_valid && !out_ready))
        else $error("pixel taken while result word is stalled");

    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_pixel |-> tex_u == 10'd0 && tex_v == 10'd0
                                   && texel_index == 20'd0 && ceiling_row == 11'd0)
        else $error("bad pixel carries texel data");

    a_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bad_pixel |->
            texel_index == (({10'd0, tex_v} << TEX_W_LOG2) + {10'd0, tex_u}))
        else $error("texel index does not match coordinates");

endmodule

bind floor_ceiling_texel_address_gen_core fctag_checker #(
    .TEX_W_LOG2 (TEX_W_LOG2)
) u_fctag_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pix_ready   (pix_in.ready),
    .out_valid   (tex_out.valid),
    .out_ready   (tex_out.ready),
    .tex_u       (tex_out.tex_u),
    .tex_v       (tex_out.tex_v),
    .texel_index (tex_out.texel_index),
    .ceiling_row (tex_out.ceiling_row),
    .bad_pixel   (tex_out.bad_pixel)
);
